FILE: src/twc_pkg.sv
package twc_pkg;

    localparam int COORD_BITS_DEF   = 12;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int LN2_Q16      = 45426;
    localparam int PI_Q16       = 205887;
    localparam int HALF_PI_Q16  = 102944;
    localparam int TWO_PI_Q16   = 411775;
    localparam int CORDIC_START = 39797;
    localparam int EXP_ONE      = 65536;
    localparam int KILL_K       = 17;

    // quotient bits kept by the divider; larger ratios give a zero exponential
    localparam int QUO_BITS = 20;

    localparam logic [7:0] CFG_IMAGE_WIDTH   = 8'd0;
    localparam logic [7:0] CFG_IMAGE_HEIGHT  = 8'd1;
    localparam logic [7:0] CFG_EFFECT_RADIUS = 8'd2;
    localparam logic [7:0] CFG_TWIST_ANGLE   = 8'd3;

    typedef struct packed {
        logic               valid;
        logic [11:0]        col;
        logic [11:0]        row;
        logic signed [12:0] x;
        logic signed [12:0] y;
    } side_t;

    function automatic logic [15:0] exp_step(input logic [4:0] i);
        logic [15:0] r;
        case (i)
            5'd0:    r = 16'd45426;
            5'd1:    r = 16'd18854;
            5'd2:    r = 16'd8751;
            5'd3:    r = 16'd4230;
            5'd4:    r = 16'd2081;
            5'd5:    r = 16'd1032;
            5'd6:    r = 16'd514;
            5'd7:    r = 16'd257;
            5'd8:    r = 16'd128;
            5'd9:    r = 16'd64;
            5'd10:   r = 16'd32;
            5'd11:   r = 16'd16;
            5'd12:   r = 16'd8;
            5'd13:   r = 16'd4;
            5'd14:   r = 16'd2;
            5'd15:   r = 16'd1;
            5'd16:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] atan_step(input logic [4:0] i);
        logic [15:0] r;
        case (i)
            5'd0:    r = 16'd51472;
            5'd1:    r = 16'd30385;
            5'd2:    r = 16'd16055;
            5'd3:    r = 16'd8150;
            5'd4:    r = 16'd4091;
            5'd5:    r = 16'd2047;
            5'd6:    r = 16'd1024;
            5'd7:    r = 16'd512;
            5'd8:    r = 16'd256;
            5'd9:    r = 16'd128;
            5'd10:   r = 16'd64;
            5'd11:   r = 16'd32;
            5'd12:   r = 16'd16;
            5'd13:   r = 16'd8;
            5'd14:   r = 16'd4;
            5'd15:   r = 16'd2;
            5'd16:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: src/twirl_source_coordinate.sv
// Channel   Direction  Ports                                   Moves
// s_        in         s_valid s_ready s_out_col s_out_row     output pixel item
// m_        out        m_valid m_ready m_pix_col m_pix_row     source coordinate item
//                      m_src_col m_src_row m_in_bounds
// cfg_      in         cfg_valid cfg_ready cfg_index cfg_data  register write
//
// One item enters per clock while the output is not stalled; its path runs through the
// 20 stage restoring divider, the exp step chain and the CORDIC rotation chain.
// Reset (aresetn low, synchronous) clears every stage valid and loads the
// register defaults. A stall at the output freezes the whole pipeline, so no
// item is dropped or repeated; cfg writes are taken on every cycle.
module twirl_source_coordinate #(
    parameter int COORD_BITS   = twc_pkg::COORD_BITS_DEF,
    parameter int CORDIC_STEPS = twc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [11:0] s_out_col,
    input  logic [11:0] s_out_row,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_pix_col,
    output logic [11:0] m_pix_row,
    output logic [11:0] m_src_col,
    output logic [11:0] m_src_row,
    output logic        m_in_bounds,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [12:0]        width_reg;
    logic [12:0]        height_reg;
    logic [11:0]        radius_reg;
    logic signed [15:0] twist_reg;
    logic [23:0]        r2_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            radius_reg <= 12'd100;
            twist_reg  <= 16'sd12868;
        end else if (cfg_valid) begin
            case (cfg_index)
                twc_pkg::CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[12:0];
                twc_pkg::CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[12:0];
                twc_pkg::CFG_EFFECT_RADIUS: radius_reg <= cfg_data[11:0];
                twc_pkg::CFG_TWIST_ANGLE:   twist_reg  <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // radius squared follows the register in the next cycle
    always_ff @(posedge aclk) begin
        r2_reg <= 24'(radius_reg) * 24'(radius_reg);
    end

    logic [11:0] cx;
    logic [11:0] cy;
    assign cx = width_reg[12:1];
    assign cy = height_reg[12:1];

    // advance every stage unless a finished item is waiting
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage: offset from centre
    twc_pkg::side_t side_a_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_a_reg.valid <= 1'b0;
        end else if (en) begin
            side_a_reg.valid <= s_valid;
            side_a_reg.col   <= s_out_col;
            side_a_reg.row   <= s_out_row;
            side_a_reg.x     <= $signed({1'b0, s_out_col}) - $signed({1'b0, cx});
            side_a_reg.y     <= $signed({1'b0, s_out_row}) - $signed({1'b0, cy});
        end
    end

    // stage: squares
    twc_pkg::side_t     side_q_reg;
    logic signed [25:0] xx_reg;
    logic signed [25:0] yy_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_q_reg.valid <= 1'b0;
        end else if (en) begin
            side_q_reg <= side_a_reg;
            xx_reg     <= side_a_reg.x * side_a_reg.x;
            yy_reg     <= side_a_reg.y * side_a_reg.y;
        end
    end

    // stage: squared distance
    twc_pkg::side_t side_d_reg;
    logic [25:0]    d2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_d_reg.valid <= 1'b0;
        end else if (en) begin
            side_d_reg <= side_q_reg;
            d2_reg     <= $unsigned(xx_reg) + $unsigned(yy_reg);
        end
    end

    // ratio d2 / r2 in Q16
    twc_pkg::side_t side_dv;
    logic [twc_pkg::QUO_BITS-1:0] t_q;
    logic t_ovf;

    twc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_d_reg),
        .d2       (d2_reg),
        .r2       (r2_reg),
        .side_out (side_dv),
        .t        (t_q),
        .ovf      (t_ovf)
    );

    // twist angle with falloff
    twc_pkg::side_t     side_e;
    logic signed [17:0] angle;

    twc_exp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_exp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .side_in     (side_dv),
        .t           (t_q),
        .ovf         (t_ovf),
        .twist       (twist_reg),
        .radius_zero (radius_reg == 12'd0),
        .side_out    (side_e),
        .angle       (angle)
    );

    // sine and cosine
    twc_pkg::side_t     side_c;
    logic signed [19:0] sn;
    logic signed [19:0] cs;

    twc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .side_in  (side_e),
        .angle    (angle),
        .side_out (side_c),
        .sn       (sn),
        .cs       (cs)
    );

    // stage: rotation products
    twc_pkg::side_t     side_p_reg;
    logic signed [32:0] cx_x_reg;
    logic signed [32:0] sn_y_reg;
    logic signed [32:0] sn_x_reg;
    logic signed [32:0] cs_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_p_reg.valid <= 1'b0;
        end else if (en) begin
            side_p_reg <= side_c;
            cx_x_reg   <= cs * side_c.x;
            sn_y_reg   <= sn * side_c.y;
            sn_x_reg   <= sn * side_c.x;
            cs_y_reg   <= cs * side_c.y;
        end
    end

    // stage: add the centre back, Q16
    twc_pkg::side_t     side_s_reg;
    logic signed [35:0] su_reg;
    logic signed [35:0] sv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_s_reg.valid <= 1'b0;
        end else if (en) begin
            side_s_reg <= side_p_reg;
            su_reg <= $signed({8'b0, cx, 16'b0}) + 36'(cx_x_reg) + 36'(sn_y_reg);
            sv_reg <= $signed({8'b0, cy, 16'b0}) - 36'(sn_x_reg) + 36'(cs_y_reg);
        end
    end

    // stage: truncate toward zero, saturate, bounds check
    localparam logic signed [19:0] TOP = 20'((1 << COORD_BITS) - 1);
    localparam logic signed [35:0] RND = 36'sd65535;

    logic signed [35:0] su_r;
    logic signed [35:0] sv_r;
    logic signed [19:0] u;
    logic signed [19:0] v;

    assign su_r = su_reg + (su_reg[35] ? RND : 36'sd0);
    assign sv_r = sv_reg + (sv_reg[35] ? RND : 36'sd0);
    assign u    = su_r[35:16];
    assign v    = sv_r[35:16];

    logic [11:0] src_col_c;
    logic [11:0] src_row_c;
    logic        inb_c;

    always_comb begin
        if (u[19])      src_col_c = '0;
        else if (u > TOP) src_col_c = TOP[11:0];
        else            src_col_c = u[11:0];
        if (v[19])      src_row_c = '0;
        else if (v > TOP) src_row_c = TOP[11:0];
        else            src_row_c = v[11:0];
        inb_c = !u[19] && (u < $signed({7'b0, width_reg})) &&
                !v[19] && (v < $signed({7'b0, height_reg}));
    end

    logic [11:0] pix_col_reg;
    logic [11:0] pix_row_reg;
    logic [11:0] src_col_reg;
    logic [11:0] src_row_reg;
    logic        in_bounds_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg   <= side_s_reg.valid;
            pix_col_reg   <= side_s_reg.col;
            pix_row_reg   <= side_s_reg.row;
            src_col_reg   <= src_col_c;
            src_row_reg   <= src_row_c;
            in_bounds_reg <= inb_c;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pix_col   = pix_col_reg;
    assign m_pix_row   = pix_row_reg;
    assign m_src_col   = src_col_reg;
    assign m_src_row   = src_row_reg;
    assign m_in_bounds = in_bounds_reg;

    // no intake while a result is held
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken during output stall");

    // an in-bounds source column stays below the image width
    a_inb_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_in_bounds) |-> ({1'b0, m_src_col} < width_reg))
        else $error("in-bounds item outside image");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid after reset");

endmodule

FILE: src/twc_div.sv
module twc_div (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  twc_pkg::side_t      side_in,
    input  logic [25:0]         d2,
    input  logic [23:0]         r2,
    output twc_pkg::side_t      side_out,
    output logic [twc_pkg::QUO_BITS-1:0] t,
    output logic                ovf
);
    localparam int QB = twc_pkg::QUO_BITS;

    twc_pkg::side_t side_reg [QB];
    logic [24:0]    rem_reg  [QB];
    logic [QB-1:0]  q_reg    [QB];
    logic [3:0]     low_reg  [QB];
    logic           ovf_reg  [QB];

    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_step
            twc_pkg::side_t s_in;
            logic [24:0]    r_in;
            logic [QB-1:0]  q_in;
            logic [3:0]     l_in;
            logic           o_in;
            logic [24:0]    trial;
            logic           nb;

            if (j == 0) begin : g_first
                // quotient is known to fit when d2 < r2 * 16
                assign s_in = side_in;
                assign r_in = 25'(d2[25:4]);
                assign q_in = '0;
                assign l_in = d2[3:0];
                assign o_in = {2'b0, d2} >= {r2, 4'b0};
            end else begin : g_next
                assign s_in = side_reg[j-1];
                assign r_in = rem_reg[j-1];
                assign q_in = q_reg[j-1];
                assign l_in = low_reg[j-1];
                assign o_in = ovf_reg[j-1];
            end

            assign nb    = (j < 4) ? l_in[3 - (j % 4)] : 1'b0;
            assign trial = {r_in[23:0], nb};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    side_reg[j].valid <= 1'b0;
                end else if (en) begin
                    side_reg[j] <= s_in;
                    low_reg[j]  <= l_in;
                    ovf_reg[j]  <= o_in;
                    if (trial >= {1'b0, r2}) begin
                        rem_reg[j] <= trial - {1'b0, r2};
                        q_reg[j]   <= {q_in[QB-2:0], 1'b1};
                    end else begin
                        rem_reg[j] <= trial;
                        q_reg[j]   <= {q_in[QB-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign side_out = side_reg[QB-1];
    assign t        = q_reg[QB-1];
    assign ovf      = ovf_reg[QB-1];

endmodule

FILE: src/twc_exp.sv
module twc_exp #(
    parameter int CORDIC_STEPS = twc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  twc_pkg::side_t      side_in,
    input  logic [twc_pkg::QUO_BITS-1:0] t,
    input  logic                ovf,
    input  logic signed [15:0]  twist,
    input  logic                radius_zero,
    output twc_pkg::side_t      side_out,
    output logic signed [17:0]  angle
);
    localparam int QB = twc_pkg::QUO_BITS;
    localparam logic [20:0] LN2 = 21'(twc_pkg::LN2_Q16);

    // split ratio into k * ln2 + f
    logic [4:0]  k_c;
    logic        kill_c;

    always_comb begin
        k_c = '0;
        for (int j = 1; j < twc_pkg::KILL_K; j++) begin
            if (t >= QB'(j * twc_pkg::LN2_Q16)) k_c = 5'(j);
        end
        kill_c = ovf || (t >= QB'(twc_pkg::KILL_K * twc_pkg::LN2_Q16));
    end

    twc_pkg::side_t side_k_reg;
    logic [QB-1:0]  t_k_reg;
    logic [4:0]     k_k_reg;
    logic           kill_k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_k_reg.valid <= 1'b0;
        end else if (en) begin
            side_k_reg <= side_in;
            t_k_reg    <= t;
            k_k_reg    <= k_c;
            kill_k_reg <= kill_c;
        end
    end

    twc_pkg::side_t side_f_reg;
    logic [15:0]    f_f_reg;
    logic [4:0]     k_f_reg;
    logic           kill_f_reg;
    logic [20:0]    kl;

    assign kl = 21'(k_k_reg) * LN2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_f_reg.valid <= 1'b0;
        end else if (en) begin
            side_f_reg <= side_k_reg;
            f_f_reg    <= 16'(t_k_reg - kl[QB-1:0]);
            k_f_reg    <= k_k_reg;
            kill_f_reg <= kill_k_reg;
        end
    end

    twc_pkg::side_t side_reg [CORDIC_STEPS];
    logic [15:0]    f_reg    [CORDIC_STEPS];
    logic [16:0]    e_reg    [CORDIC_STEPS];
    logic [4:0]     k_reg    [CORDIC_STEPS];
    logic           kill_reg [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            twc_pkg::side_t s_in;
            logic [15:0]    f_in;
            logic [16:0]    e_in;
            logic [4:0]     k_in;
            logic           kl_in;
            logic [15:0]    lim;

            if (i == 0) begin : g_first
                assign s_in  = side_f_reg;
                assign f_in  = f_f_reg;
                assign e_in  = 17'(twc_pkg::EXP_ONE);
                assign k_in  = k_f_reg;
                assign kl_in = kill_f_reg;
            end else begin : g_next
                assign s_in  = side_reg[i-1];
                assign f_in  = f_reg[i-1];
                assign e_in  = e_reg[i-1];
                assign k_in  = k_reg[i-1];
                assign kl_in = kill_reg[i-1];
            end

            assign lim = twc_pkg::exp_step(5'(i));

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    side_reg[i].valid <= 1'b0;
                end else if (en) begin
                    side_reg[i] <= s_in;
                    k_reg[i]    <= k_in;
                    kill_reg[i] <= kl_in;
                    if (f_in >= lim) begin
                        f_reg[i] <= f_in - lim;
                        e_reg[i] <= e_in - (e_in >> (i + 1));
                    end else begin
                        f_reg[i] <= f_in;
                        e_reg[i] <= e_in;
                    end
                end
            end
        end
    endgenerate

    twc_pkg::side_t side_s_reg;
    logic [16:0]    e_s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_s_reg.valid <= 1'b0;
        end else if (en) begin
            side_s_reg <= side_reg[CORDIC_STEPS-1];
            e_s_reg    <= kill_reg[CORDIC_STEPS-1] ? 17'd0 :
                          (e_reg[CORDIC_STEPS-1] >> k_reg[CORDIC_STEPS-1]);
        end
    end

    twc_pkg::side_t side_m_reg;
    logic [16:0]    mag_m_reg;
    logic [15:0]    twist_mag;
    logic [32:0]    prod;

    assign twist_mag = twist[15] ? 16'(-twist) : 16'(twist);
    assign prod      = 33'(twist_mag) * 33'(e_s_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_m_reg.valid <= 1'b0;
        end else if (en) begin
            side_m_reg <= side_s_reg;
            mag_m_reg  <= prod[32:16];
        end
    end

    twc_pkg::side_t     side_a_reg;
    logic signed [17:0] angle_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_a_reg.valid <= 1'b0;
        end else if (en) begin
            side_a_reg <= side_m_reg;
            if (radius_zero)    angle_reg <= '0;
            else if (twist[15]) angle_reg <= -$signed({1'b0, mag_m_reg});
            else                angle_reg <= $signed({1'b0, mag_m_reg});
        end
    end

    assign side_out = side_a_reg;
    assign angle    = angle_reg;

endmodule

FILE: src/twc_cordic.sv
module twc_cordic #(
    parameter int CORDIC_STEPS = twc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  twc_pkg::side_t      side_in,
    input  logic signed [17:0]  angle,
    output twc_pkg::side_t      side_out,
    output logic signed [19:0]  sn,
    output logic signed [19:0]  cs
);
    localparam logic signed [21:0] PI      = 22'(twc_pkg::PI_Q16);
    localparam logic signed [21:0] HALF_PI = 22'(twc_pkg::HALF_PI_Q16);
    localparam logic signed [21:0] TWO_PI  = 22'(twc_pkg::TWO_PI_Q16);

    // one wrap by two pi is enough for the angle range
    logic signed [21:0] z_in;
    assign z_in = {angle, 4'b0};

    twc_pkg::side_t     side_r_reg;
    logic signed [21:0] z_r_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_r_reg.valid <= 1'b0;
        end else if (en) begin
            side_r_reg <= side_in;
            if (z_in > PI)        z_r_reg <= z_in - TWO_PI;
            else if (z_in <= -PI) z_r_reg <= z_in + TWO_PI;
            else                  z_r_reg <= z_in;
        end
    end

    twc_pkg::side_t     side_h_reg;
    logic signed [21:0] z_h_reg;
    logic               flip_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_h_reg.valid <= 1'b0;
        end else if (en) begin
            side_h_reg <= side_r_reg;
            if (z_r_reg > HALF_PI) begin
                z_h_reg    <= z_r_reg - PI;
                flip_h_reg <= 1'b1;
            end else if (z_r_reg < -HALF_PI) begin
                z_h_reg    <= z_r_reg + PI;
                flip_h_reg <= 1'b1;
            end else begin
                z_h_reg    <= z_r_reg;
                flip_h_reg <= 1'b0;
            end
        end
    end

    twc_pkg::side_t     side_reg [CORDIC_STEPS];
    logic signed [19:0] x_reg    [CORDIC_STEPS];
    logic signed [19:0] y_reg    [CORDIC_STEPS];
    logic signed [21:0] z_reg    [CORDIC_STEPS];
    logic               flip_reg [CORDIC_STEPS];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
            twc_pkg::side_t     s_in;
            logic signed [19:0] x_in;
            logic signed [19:0] y_in;
            logic signed [21:0] zz_in;
            logic               fl_in;
            logic signed [21:0] at;

            if (i == 0) begin : g_first
                assign s_in  = side_h_reg;
                assign x_in  = 20'(twc_pkg::CORDIC_START);
                assign y_in  = '0;
                assign zz_in = z_h_reg;
                assign fl_in = flip_h_reg;
            end else begin : g_next
                assign s_in  = side_reg[i-1];
                assign x_in  = x_reg[i-1];
                assign y_in  = y_reg[i-1];
                assign zz_in = z_reg[i-1];
                assign fl_in = flip_reg[i-1];
            end

            assign at = $signed({6'b0, twc_pkg::atan_step(5'(i))});

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    side_reg[i].valid <= 1'b0;
                end else if (en) begin
                    side_reg[i] <= s_in;
                    flip_reg[i] <= fl_in;
                    if (!zz_in[21]) begin
                        x_reg[i] <= x_in - (y_in >>> i);
                        y_reg[i] <= y_in + (x_in >>> i);
                        z_reg[i] <= zz_in - at;
                    end else begin
                        x_reg[i] <= x_in + (y_in >>> i);
                        y_reg[i] <= y_in - (x_in >>> i);
                        z_reg[i] <= zz_in + at;
                    end
                end
            end
        end
    endgenerate

    twc_pkg::side_t     side_o_reg;
    logic signed [19:0] sn_reg;
    logic signed [19:0] cs_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_o_reg.valid <= 1'b0;
        end else if (en) begin
            side_o_reg <= side_reg[CORDIC_STEPS-1];
            if (flip_reg[CORDIC_STEPS-1]) begin
                sn_reg <= -y_reg[CORDIC_STEPS-1];
                cs_reg <= -x_reg[CORDIC_STEPS-1];
            end else begin
                sn_reg <= y_reg[CORDIC_STEPS-1];
                cs_reg <= x_reg[CORDIC_STEPS-1];
            end
        end
    end

    assign side_out = side_o_reg;
    assign sn       = sn_reg;
    assign cs       = cs_reg;

endmodule

FILE: sim/twirl_source_coordinate_chk.sv
module twirl_source_coordinate_chk (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [11:0] s_out_col,
    input  logic [11:0] s_out_row,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [11:0] m_pix_col,
    input  logic [11:0] m_pix_row,
    input  logic [11:0] m_src_col,
    input  logic [11:0] m_src_row,
    input  logic        m_in_bounds,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [11:0] pix_col;
        logic [11:0] pix_row;
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic        in_bounds;
    } src_coord_t;

    src_coord_t       coord_queue[$];
    logic [12:0]      width_reg;
    logic [12:0]      height_reg;
    logic [11:0]      radius_reg;
    logic signed [15:0] twist_reg;

    function automatic longint floor_sh(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-v - 1) >>> s) - 1;
    endfunction

    function automatic longint gauss_q16(longint t);
        longint k, f, e;
        k = t / twc_pkg::LN2_Q16;
        e = twc_pkg::EXP_ONE;
        if (k > 16) return 0;
        f = t - k * twc_pkg::LN2_Q16;
        for (int i = 1; i <= twc_pkg::CORDIC_STEPS_DEF; i++) begin
            if (f >= longint'(twc_pkg::exp_step(5'(i - 1)))) begin
                f -= twc_pkg::exp_step(5'(i - 1));
                e -= e >>> i;
            end
        end
        return e >>> k;
    endfunction

    function automatic logic [11:0] clamp_coord(longint v);
        if (v < 0) return 12'd0;
        if (v > 4095) return 12'd4095;
        return v[11:0];
    endfunction

    function automatic src_coord_t warp_pixel(logic [11:0] col, logic [11:0] row);
        src_coord_t r;
        longint cx, cy, x, y, ang, mag, z, sx, cs, ny, u, v, t;
        bit flip;
        cx = width_reg >> 1;
        cy = height_reg >> 1;
        x = longint'(col) - cx;
        y = longint'(row) - cy;
        ang = 0;
        if (radius_reg != 0) begin
            t = ((x * x + y * y) << 16) / (longint'(radius_reg) * radius_reg);
            mag = twist_reg < 0 ? -longint'(twist_reg) : longint'(twist_reg);
            mag = (mag * gauss_q16(t)) >>> 16;
            ang = twist_reg < 0 ? -mag : mag;
        end
        z = ang * 16;
        flip = 0;
        while (z > twc_pkg::PI_Q16) z -= twc_pkg::TWO_PI_Q16;
        while (z <= -twc_pkg::PI_Q16) z += twc_pkg::TWO_PI_Q16;
        if (z > twc_pkg::HALF_PI_Q16) begin
            z -= twc_pkg::PI_Q16; flip = 1;
        end else if (z < -twc_pkg::HALF_PI_Q16) begin
            z += twc_pkg::PI_Q16; flip = 1;
        end
        cs = twc_pkg::CORDIC_START;
        sx = 0;
        for (int i = 0; i < twc_pkg::CORDIC_STEPS_DEF; i++) begin
            if (z >= 0) begin
                ny = cs - floor_sh(sx, i);
                sx = sx + floor_sh(cs, i);
                z -= twc_pkg::atan_step(5'(i));
            end else begin
                ny = cs + floor_sh(sx, i);
                sx = sx - floor_sh(cs, i);
                z += twc_pkg::atan_step(5'(i));
            end
            cs = ny;
        end
        if (flip) begin
            sx = -sx; cs = -cs;
        end
        u = (cx * 65536 + cs * x + sx * y) / 65536;
        v = (cy * 65536 - sx * x + cs * y) / 65536;
        r.pix_col = col;
        r.pix_row = row;
        r.src_col = clamp_coord(u);
        r.src_row = clamp_coord(v);
        r.in_bounds = u >= 0 && u < width_reg && v >= 0 && v < height_reg;
        return r;
    endfunction

    always @(posedge aclk) begin
        src_coord_t want;
        src_coord_t got;
        if (!aresetn) begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            radius_reg <= 12'd100;
            twist_reg  <= 16'sd12868;
            coord_queue.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready)
                coord_queue.push_back(warp_pixel(s_out_col, s_out_row));
            if (m_valid && m_ready) begin
                got = '{m_pix_col, m_pix_row, m_src_col, m_src_row, m_in_bounds};
                if (coord_queue.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected item col=%0d row=%0d",
                                 m_pix_col, m_pix_row);
                    fail_count <= fail_count + 1;
                end else begin
                    want = coord_queue.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"mismatch pix=(%0d,%0d) exp src=(%0d,%0d,%0b) ",
                                      "got (%0d,%0d) src=(%0d,%0d,%0b)"},
                                     want.pix_col, want.pix_row, want.src_col,
                                     want.src_row, want.in_bounds, got.pix_col,
                                     got.pix_row, got.src_col, got.src_row,
                                     got.in_bounds);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= coord_queue.size();
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    twc_pkg::CFG_IMAGE_WIDTH:   width_reg  <= cfg_data[12:0];
                    twc_pkg::CFG_IMAGE_HEIGHT:  height_reg <= cfg_data[12:0];
                    twc_pkg::CFG_EFFECT_RADIUS: radius_reg <= cfg_data[11:0];
                    twc_pkg::CFG_TWIST_ANGLE:   twist_reg  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: sim/twirl_source_coordinate_tb.sv
module twirl_source_coordinate_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 2 * twc_pkg::CORDIC_STEPS_DEF + 34;
    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [11:0] s_out_col = 0;
    logic [11:0] s_out_row = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [11:0] m_pix_col, m_pix_row, m_src_col, m_src_row;
    logic        m_in_bounds;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = 0;
    logic [15:0] cfg_data = 0;
    int          fail_count;
    int          pending;
    bit          calm = 0;     // long stretch with no idling on either side
    longint      cycle_count = 0;

    twirl_source_coordinate uut (.*);
    twirl_source_coordinate_chk chk (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // hard limit on the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side: stall with a chance of about 13 percent unless calm
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 13);
    end

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 0;
    endtask

    // present one pixel item, with a random gap ahead unless calm
    task automatic send_pixel(logic [11:0] col, logic [11:0] row);
        while (!calm && $urandom_range(99) < 13) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid   <= 1;
        s_out_col <= col;
        s_out_row <= row;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold off until every expected item has come out, plus pipeline depth
    task automatic drain_pipe();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // pixels near the centre of the current setting, so the twist is strong
    task automatic send_near(int cx, int cy, int spread, int count);
        int c, r;
        repeat (count) begin
            c = cx + $signed($urandom_range(2 * spread)) - spread;
            r = cy + $signed($urandom_range(2 * spread)) - spread;
            if (c < 0) c = 0;
            if (c > 4095) c = 4095;
            if (r < 0) r = 0;
            if (r > 4095) r = 4095;
            send_pixel(12'(c), 12'(r));
        end
    endtask

    task automatic send_any(int count);
        repeat (count) send_pixel(12'($urandom), 12'($urandom));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: reset settings, corners and centre
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd330, 12'd250);
        send_pixel(12'd2730, 12'd1365);
        drain_pipe();

        // zero radius: no twist
        write_reg(twc_pkg::CFG_EFFECT_RADIUS, 16'h0000);
        send_pixel(12'd100, 12'd50);
        send_pixel(12'd700, 12'd10);
        drain_pipe();

        // zero width and height, extreme negative twist, upper bits ignored
        write_reg(twc_pkg::CFG_IMAGE_WIDTH, 16'hE000);
        write_reg(twc_pkg::CFG_IMAGE_HEIGHT, 16'hE000);
        write_reg(twc_pkg::CFG_EFFECT_RADIUS, 16'hF001);
        write_reg(twc_pkg::CFG_TWIST_ANGLE, 16'h8000);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd0, 12'd1);
        drain_pipe();

        // largest sizes, largest positive twist
        write_reg(twc_pkg::CFG_IMAGE_WIDTH, 16'd4096);
        write_reg(twc_pkg::CFG_IMAGE_HEIGHT, 16'd4096);
        write_reg(twc_pkg::CFG_EFFECT_RADIUS, 16'd4095);
        write_reg(twc_pkg::CFG_TWIST_ANGLE, 16'h7FFF);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd3000, 12'd1000);
        send_pixel(12'd2048, 12'd0);
        send_any(40);
        drain_pipe();

        // random settings: mostly pixels near the centre, some anywhere
        for (int ph = 0; ph < 8; ph++) begin
            logic [15:0] w, h, rad, tw;
            w   = 16'($urandom_range(4096, 1)) | (16'($urandom) & 16'hE000);
            h   = 16'($urandom_range(4096, 1)) | (16'($urandom) & 16'hE000);
            rad = 16'($urandom_range(ph == 0 ? 1 : 600, 1)) | (16'($urandom) & 16'hF000);
            tw  = 16'($urandom);
            write_reg(twc_pkg::CFG_IMAGE_WIDTH, w);
            write_reg(twc_pkg::CFG_IMAGE_HEIGHT, h);
            write_reg(twc_pkg::CFG_EFFECT_RADIUS, rad);
            write_reg(twc_pkg::CFG_TWIST_ANGLE, tw);
            calm = (ph == 3);
            send_near(w[12:0] / 2, h[12:0] / 2, 3 * rad[11:0] + 2, 60);
            send_any(25);
            calm = 0;
            drain_pipe();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
